// ----- rtl/core/ham6_pkg.sv -----
// ham6_pkg: shared types, constants and helpers for the hold-and-modify pixel writer
// depends on nothing; imported by every module of the core
`default_nettype none
package ham6_pkg;

    // frame store geometry; row stride is the maximum width, a power of two,
    // so a store address is simply {row, column}
    localparam int MAX_WIDTH       = 512;
    localparam int MAX_HEIGHT      = 256;
    localparam int PALETTE_ENTRIES = 16;

    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = X_W + Y_W;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam int CH_W   = 4;
    localparam int OUT_W  = 8;
    localparam int PEN_W  = 6;
    localparam int FW_W   = 10;
    localparam int FH_W   = 9;
    localparam int PAL_W  = PALETTE_ENTRIES * CH_W;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 64;

    localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FH_MAX   = FH_W'(MAX_HEIGHT);
    localparam logic [FW_W-1:0] FW_RESET = FW_W'(320);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(200);

    // configuration register indexes
    localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_PALETTE_RED   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_PALETTE_GREEN = 3'd3;
    localparam logic [CFG_IW-1:0] REG_PALETTE_BLUE  = 3'd4;

    // pen modes, bits 5..4 of the pen
    localparam logic [1:0] MODE_PALETTE = 2'd0;
    localparam logic [1:0] MODE_BLUE    = 2'd1;
    localparam logic [1:0] MODE_RED     = 2'd2;
    localparam logic [1:0] MODE_GREEN   = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } colour_t;

    // effective frame size and palette banks
    typedef struct packed {
        logic [FW_W-1:0]  width;
        logic [FH_W-1:0]  height;
        logic [PAL_W-1:0] pal_red;
        logic [PAL_W-1:0] pal_green;
        logic [PAL_W-1:0] pal_blue;
    } cfg_t;

    // one read and one write access to the frame store
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        colour_t           wr_data;
    } store_req_t;

    // channel times 17 is the nibble repeated
    function automatic logic [OUT_W-1:0] expand_ch(input logic [CH_W-1:0] c);
        return {c, c};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ham6_cfg_regs.sv -----
// ham6_cfg_regs: frame size and palette registers behind the plain write port
// depends on ham6_pkg
`default_nettype none
module ham6_cfg_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [ham6_pkg::CFG_IW-1:0]  cfg_index,
    input  wire logic [ham6_pkg::CFG_DW-1:0]  cfg_wdata,
    output ham6_pkg::cfg_t                    cfg
);
    import ham6_pkg::*;

    logic [FW_W-1:0]  width_reg,  width_next;
    logic [FH_W-1:0]  height_reg, height_next;
    logic [PAL_W-1:0] pal_r_reg,  pal_r_next;
    logic [PAL_W-1:0] pal_g_reg,  pal_g_next;
    logic [PAL_W-1:0] pal_b_reg,  pal_b_next;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        pal_r_next  = pal_r_reg;
        pal_g_next  = pal_g_reg;
        pal_b_next  = pal_b_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH:   width_next  = cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT:  height_next = cfg_wdata[FH_W-1:0];
                REG_PALETTE_RED:   pal_r_next  = cfg_wdata[PAL_W-1:0];
                REG_PALETTE_GREEN: pal_g_next  = cfg_wdata[PAL_W-1:0];
                REG_PALETTE_BLUE:  pal_b_next  = cfg_wdata[PAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= FW_RESET;
            height_reg <= FH_RESET;
            pal_r_reg  <= '0;
            pal_g_reg  <= '0;
            pal_b_reg  <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            pal_r_reg  <= pal_r_next;
            pal_g_reg  <= pal_g_next;
            pal_b_reg  <= pal_b_next;
        end
    end

    // oversized frames clamp to the store size
    always_comb begin
        cfg.width     = (width_reg > FW_MAX) ? FW_MAX : width_reg;
        cfg.height    = (height_reg > FH_MAX) ? FH_MAX : height_reg;
        cfg.pal_red   = pal_r_reg;
        cfg.pal_green = pal_g_reg;
        cfg.pal_blue  = pal_b_reg;
    end

endmodule
`default_nettype wire

// ----- rtl/core/ham6_colour_store.sv -----
// ham6_colour_store: frame store memory with registered read and a clearing sweep
// depends on ham6_pkg
`default_nettype none
module ham6_colour_store (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire ham6_pkg::store_req_t req,
    output ham6_pkg::colour_t  rd_data,
    output logic               clr_busy
);
    import ham6_pkg::*;

    colour_t mem [STORE_DEPTH];
    colour_t rd_data_reg;

    logic              clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0] clr_cnt_reg,  clr_cnt_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    colour_t           wr_data;

    // sweep every entry to black after reset
    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_comb begin
        wr_en   = clr_busy_reg | req.wr_en;
        wr_addr = clr_busy_reg ? clr_cnt_reg : req.wr_addr;
        wr_data = clr_busy_reg ? colour_t'('0) : req.wr_data;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule
`default_nettype wire

// ----- rtl/core/ham6_hold_modify.sv -----
// ham6_hold_modify: pen decode, palette lookup and channel hold/modify
// depends on ham6_pkg
`default_nettype none
module ham6_hold_modify (
    input  wire ham6_pkg::colour_t           left,
    input  wire logic [ham6_pkg::PEN_W-1:0]  pen,
    input  wire ham6_pkg::cfg_t              cfg,
    output ham6_pkg::colour_t                result
);
    import ham6_pkg::*;

    logic [1:0]      mode;
    logic [CH_W-1:0] val;

    assign mode = pen[PEN_W-1:CH_W];
    assign val  = pen[CH_W-1:0];

    always_comb begin
        result = left;
        case (mode)
            MODE_PALETTE: begin
                result.red   = cfg.pal_red[val*CH_W +: CH_W];
                result.green = cfg.pal_green[val*CH_W +: CH_W];
                result.blue  = cfg.pal_blue[val*CH_W +: CH_W];
            end
            MODE_BLUE:  result.blue  = val;
            MODE_RED:   result.red   = val;
            MODE_GREEN: result.green = val;
            default:    result = left;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/ham6_pixel_frame_writer_core.sv -----
// ham6_pixel_frame_writer_core: hold-and-modify pixel writer over a 512x256 frame store
// depends on ham6_pkg, ham6_cfg_regs, ham6_colour_store, ham6_hold_modify
// an accepted word waits in the pending register for its read, then moves to the output register
// throughput: one word per cycle while the output side keeps up; the single store
//   read of the left neighbour and the write-back of the pixel overlap, with forwarding
// reset: the store is swept to black, one entry a cycle, with s_ready low throughout;
//   config writes are taken during the sweep
`default_nettype none
module ham6_pixel_frame_writer_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // config write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [ham6_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [ham6_pkg::CFG_DW-1:0]   cfg_wdata,
    // pixel write input
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ham6_pkg::X_W-1:0]      s_pixel_x,
    input  wire logic [ham6_pkg::Y_W-1:0]      s_pixel_y,
    input  wire logic [ham6_pkg::PEN_W-1:0]    s_pen,
    // result output
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [ham6_pkg::OUT_W-1:0]         m_red_out,
    output logic [ham6_pkg::OUT_W-1:0]         m_green_out,
    output logic [ham6_pkg::OUT_W-1:0]         m_blue_out,
    output logic                               m_out_of_frame,
    output logic                               m_line_end
);
    import ham6_pkg::*;

    cfg_t       cfg;
    store_req_t req;
    colour_t    rd_data;
    logic       clr_busy;

    // config registers, clamped to the store size
    ham6_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // ---------------------------------------------------------------
    // accept stage: bounds check, issue the left-neighbour read
    // ---------------------------------------------------------------
    logic              accept;
    logic              in_oof;
    logic              in_lend;
    logic              in_col0;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] in_left_addr;

    // pending word, waiting for its read data
    logic              p_valid_reg, p_valid_next;
    logic [ADDR_W-1:0] p_addr_reg;
    logic [PEN_W-1:0]  p_pen_reg;
    logic              p_oof_reg;
    logic              p_lend_reg;
    logic              p_col0_reg;
    logic              p_fwd_reg;
    colour_t           p_fwd_data_reg;

    logic              p_done;
    colour_t           left;
    colour_t           new_colour;

    // output register
    logic              m_valid_reg, m_valid_next;
    colour_t           m_colour_reg;
    logic              m_oof_reg;
    logic              m_lend_reg;

    // pending word retires when the output register is free or draining
    assign p_done  = p_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready = ~clr_busy & (~p_valid_reg | p_done);
    assign accept  = s_valid & s_ready;

    always_comb begin
        in_oof       = ({1'b0, s_pixel_x} >= cfg.width) | ({1'b0, s_pixel_y} >= cfg.height);
        // width is at least one whenever the pixel is inside the frame
        in_lend      = ~in_oof & ({1'b0, s_pixel_x} == (cfg.width - 1'b1));
        in_col0      = (s_pixel_x == '0);
        in_addr      = {s_pixel_y, s_pixel_x};
        in_left_addr = {s_pixel_y, s_pixel_x - 1'b1};
    end

    // store accesses: read the left neighbour on accept, write back on retire
    always_comb begin
        req.rd_en   = accept & ~in_oof & ~in_col0;
        req.rd_addr = in_left_addr;
        req.wr_en   = p_done & ~p_oof_reg;
        req.wr_addr = p_addr_reg;
        req.wr_data = new_colour;
    end

    ham6_colour_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .rd_data  (rd_data),
        .clr_busy (clr_busy)
    );

    always_comb begin
        p_valid_next = p_valid_reg;
        if (accept) begin
            p_valid_next = 1'b1;
        end else if (p_done) begin
            p_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
        end
    end

    // pending payload; the left neighbour may be the pixel being written
    // in this same cycle, in which case its new colour is forwarded
    always_ff @(posedge aclk) begin
        if (accept) begin
            p_addr_reg     <= in_addr;
            p_pen_reg      <= s_pen;
            p_oof_reg      <= in_oof;
            p_lend_reg     <= in_lend;
            p_col0_reg     <= in_col0;
            p_fwd_reg      <= req.wr_en & (req.wr_addr == in_left_addr);
            p_fwd_data_reg <= new_colour;
        end
    end

    // ---------------------------------------------------------------
    // modify stage: hold from the left neighbour (black at column 0)
    // ---------------------------------------------------------------
    always_comb begin
        if (p_col0_reg) begin
            left = '0;
        end else if (p_fwd_reg) begin
            left = p_fwd_data_reg;
        end else begin
            left = rd_data;
        end
    end

    ham6_hold_modify u_hm (
        .left   (left),
        .pen    (p_pen_reg),
        .cfg    (cfg),
        .result (new_colour)
    );

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (p_done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // out-of-frame words report black and are never stored
    always_ff @(posedge aclk) begin
        if (p_done) begin
            m_colour_reg <= p_oof_reg ? colour_t'('0) : new_colour;
            m_oof_reg    <= p_oof_reg;
            m_lend_reg   <= p_lend_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_red_out      = expand_ch(m_colour_reg.red);
    assign m_green_out    = expand_ch(m_colour_reg.green);
    assign m_blue_out     = expand_ch(m_colour_reg.blue);
    assign m_out_of_frame = m_oof_reg;
    assign m_line_end     = m_lend_reg;

endmodule
`default_nettype wire
